// File: rtl/trb_pkg.sv
// trb_pkg: shared types and constants of the TRB producer ring.
// Used by trb_ctrl, trb_datapath and trb_producer_ring. No dependencies.
`timescale 1ns / 1ps

package trb_pkg;

  // Default sizing
  localparam int SLOT_COUNT_DEF = 256;
  localparam int TAG_BITS_DEF   = 8;

  // Link TRB control word fields
  localparam logic [31:0] LINK_TYPE         = 32'd6;
  localparam int          TYPE_SHIFT        = 10;
  localparam logic [31:0] TOGGLE_CYCLE_FLAG = 32'd1 << 1;
  localparam logic [31:0] LINK_CTRL         = (LINK_TYPE << TYPE_SHIFT) | TOGGLE_CYCLE_FLAG;

  // Request codes
  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_EVENT = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_WRITE     = 2'd0;
  localparam logic [1:0] KIND_TAG       = 2'd1;
  localparam logic [1:0] KIND_NO_WAITER = 2'd2;
  localparam logic [1:0] KIND_RANGE     = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch the request payload
    logic push_wr;    // emit TRB write, update tag store and slot
    logic link_wr;    // emit link TRB, toggle cycle bit
    logic ev_index;   // compute slot index from event pointer
    logic ev_read;    // read tag store at that index
    logic ev_result;  // emit completion result
  } trb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic wrap;       // current push reaches the last slot
  } trb_sts_t;

endpackage

// File: rtl/trb_producer_ring.sv
// trb_producer_ring: a push goes from start through the push state to its result strobe,
// then through the link state for the link TRB when it reaches the last slot; the next start
// is taken in the cycle the last result shows. A completion steps through index subtract,
// tag memory read and result. The state machine walks one request at a time.
// Reset: slot 0, cycle bit 1, all tag valid bits and ring base cleared at once.
// Results show for one cycle on result_strobe_o; the receiver cannot stall.
`timescale 1ns / 1ps

module trb_producer_ring
  import trb_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i,
  // request
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [31:0] trb_word0_i,
  input  logic [31:0] trb_word1_i,
  input  logic [31:0] trb_word2_i,
  input  logic [31:0] trb_word3_i,
  input  logic        tag_present_i,
  input  logic [7:0]  waiter_tag_i,
  input  logic [63:0] event_pointer_i,
  // results
  output logic        result_strobe_o,
  output logic [1:0]  result_kind_o,
  output logic [63:0] write_address_o,
  output logic [31:0] out_word0_o,
  output logic [31:0] out_word1_o,
  output logic [31:0] out_word2_o,
  output logic [31:0] out_word3_o,
  output logic [7:0]  delivered_tag_o,
  output logic        last_result_o
);

  trb_cmd_t cmd;
  trb_sts_t sts;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  trb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  trb_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .TAG_BITS   (TAG_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .trb_word0_i     (trb_word0_i),
    .trb_word1_i     (trb_word1_i),
    .trb_word2_i     (trb_word2_i),
    .trb_word3_i     (trb_word3_i),
    .tag_present_i   (tag_present_i),
    .waiter_tag_i    (waiter_tag_i),
    .event_pointer_i (event_pointer_i),
    .result_strobe_o (result_strobe_o),
    .result_kind_o   (result_kind_o),
    .write_address_o (write_address_o),
    .out_word0_o     (out_word0_o),
    .out_word1_o     (out_word1_o),
    .out_word2_o     (out_word2_o),
    .out_word3_o     (out_word3_o),
    .delivered_tag_o (delivered_tag_o),
    .last_result_o   (last_result_o)
  );

endmodule

// File: rtl/trb_ctrl.sv
// trb_ctrl: sequencing state machine of the TRB producer ring.
// Depends on trb_pkg (command and status structs, request codes).
`timescale 1ns / 1ps

module trb_ctrl
  import trb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     func_i,
  input  trb_sts_t sts_i,
  output trb_cmd_t cmd_o,
  output logic     busy
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PUSH = 6'b000010,
    ST_LINK = 6'b000100,
    ST_EIDX = 6'b001000,
    ST_ERD  = 6'b010000,
    ST_ERES = 6'b100000
  } trb_state_e;

  trb_state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = (func_i == FUNC_EVENT) ? ST_EIDX : ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd_o.push_wr = 1'b1;
        state_d       = sts_i.wrap ? ST_LINK : ST_IDLE;
      end
      ST_LINK: begin
        cmd_o.link_wr = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_EIDX: begin
        cmd_o.ev_index = 1'b1;
        state_d        = ST_ERD;
      end
      ST_ERD: begin
        cmd_o.ev_read = 1'b1;
        state_d       = ST_ERES;
      end
      ST_ERES: begin
        cmd_o.ev_result = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

// File: rtl/trb_datapath.sv
// trb_datapath: ring base, enqueue slot, cycle bit, tag store and result registers.
// Depends on trb_pkg (commands, result kinds, link TRB constants).
`timescale 1ns / 1ps

module trb_datapath
  import trb_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  trb_cmd_t    cmd_i,
  output trb_sts_t    sts_o,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_data_i,
  input  logic [31:0] trb_word0_i,
  input  logic [31:0] trb_word1_i,
  input  logic [31:0] trb_word2_i,
  input  logic [31:0] trb_word3_i,
  input  logic        tag_present_i,
  input  logic [7:0]  waiter_tag_i,
  input  logic [63:0] event_pointer_i,
  output logic        result_strobe_o,
  output logic [1:0]  result_kind_o,
  output logic [63:0] write_address_o,
  output logic [31:0] out_word0_o,
  output logic [31:0] out_word1_o,
  output logic [31:0] out_word2_o,
  output logic [31:0] out_word3_o,
  output logic [7:0]  delivered_tag_o,
  output logic        last_result_o
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);

  // Configuration and ring state
  logic [63:0]         base_q;
  logic [SLOT_W-1:0]   enq_q;
  logic                cycle_q;
  logic [SLOT_W-1:0]   link_slot_q;
  logic [SLOT_COUNT-1:0] tag_vld_q;

  // Request payload
  logic [31:0] w0_q, w1_q, w2_q, w3_q;
  logic        tag_pres_q;
  logic [7:0]  tag_in_q;
  logic [63:0] ptr_q;

  // Completion lookup
  logic [SLOT_W-1:0]   idx_q;
  logic                oor_q;
  logic                vld_rd_q;
  logic [TAG_BITS-1:0] tag_rd_q;
  logic [TAG_BITS-1:0] tag_mem [SLOT_COUNT];

  // Result registers
  logic        strobe_q;
  logic [1:0]  kind_q;
  logic [63:0] addr_q;
  logic [31:0] ow0_q, ow1_q, ow2_q, ow3_q;
  logic [7:0]  dtag_q;
  logic        last_q;

  logic [SLOT_W-1:0] slot_eff;
  logic [SLOT_W-1:0] slot_nxt;
  logic              wrap;
  logic [63:0]       ptr_diff;

  // Slot to use: anything at or past the link slot restarts at zero
  always_comb begin
    slot_eff = (enq_q >= SLOT_W'(SLOT_COUNT - 1)) ? '0 : enq_q;
    slot_nxt = slot_eff + SLOT_W'(1);
    wrap     = (slot_eff >= SLOT_W'(SLOT_COUNT - 2));
    ptr_diff = ptr_q - base_q;
  end

  assign sts_o.wrap = wrap;

  // Payload capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      w0_q       <= trb_word0_i;
      w1_q       <= trb_word1_i;
      w2_q       <= trb_word2_i;
      w3_q       <= trb_word3_i;
      tag_pres_q <= tag_present_i;
      tag_in_q   <= waiter_tag_i;
      ptr_q      <= event_pointer_i;
    end
  end

  // Control state: base, slot, cycle bit, tag valid bits, strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      enq_q     <= '0;
      cycle_q   <= 1'b1;
      tag_vld_q <= '0;
      strobe_q  <= 1'b0;
    end else begin
      strobe_q <= cmd_i.push_wr | cmd_i.link_wr | cmd_i.ev_result;
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
      if (cmd_i.push_wr) begin
        tag_vld_q[slot_eff] <= tag_pres_q;
        enq_q               <= wrap ? '0 : slot_nxt;
      end
      if (cmd_i.link_wr) begin
        cycle_q <= ~cycle_q;
      end
      if (cmd_i.ev_result && !oor_q && vld_rd_q) begin
        tag_vld_q[idx_q] <= 1'b0;
      end
    end
  end

  // Tag memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_wr) begin
      tag_mem[slot_eff] <= TAG_BITS'(tag_in_q);
    end
    if (cmd_i.ev_read) begin
      tag_rd_q <= tag_mem[idx_q];
    end
  end

  // Completion index and range check, then valid bit lookup
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_wr) begin
      link_slot_q <= slot_nxt;
    end
    if (cmd_i.ev_index) begin
      idx_q <= ptr_diff[SLOT_W+3:4];
      oor_q <= (ptr_diff[63:4] >= 60'(SLOT_COUNT));
    end
    if (cmd_i.ev_read) begin
      vld_rd_q <= tag_vld_q[idx_q];
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_wr) begin
      kind_q <= KIND_WRITE;
      addr_q <= base_q + (64'(slot_eff) << 4);
      ow0_q  <= w0_q;
      ow1_q  <= w1_q;
      ow2_q  <= w2_q;
      ow3_q  <= {w3_q[31:1], cycle_q};
      dtag_q <= '0;
      last_q <= ~wrap;
    end else if (cmd_i.link_wr) begin
      kind_q <= KIND_WRITE;
      addr_q <= base_q + (64'(link_slot_q) << 4);
      ow0_q  <= base_q[31:0];
      ow1_q  <= base_q[63:32];
      ow2_q  <= '0;
      ow3_q  <= LINK_CTRL | 32'(cycle_q);
      dtag_q <= '0;
      last_q <= 1'b1;
    end else if (cmd_i.ev_result) begin
      addr_q <= '0;
      ow0_q  <= '0;
      ow1_q  <= '0;
      ow2_q  <= '0;
      ow3_q  <= '0;
      last_q <= 1'b1;
      if (oor_q) begin
        kind_q <= KIND_RANGE;
        dtag_q <= '0;
      end else if (vld_rd_q) begin
        kind_q <= KIND_TAG;
        dtag_q <= 8'(tag_rd_q);
      end else begin
        kind_q <= KIND_NO_WAITER;
        dtag_q <= '0;
      end
    end
  end

  assign result_strobe_o = strobe_q;
  assign result_kind_o   = kind_q;
  assign write_address_o = addr_q;
  assign out_word0_o     = ow0_q;
  assign out_word1_o     = ow1_q;
  assign out_word2_o     = ow2_q;
  assign out_word3_o     = ow3_q;
  assign delivered_tag_o = dtag_q;
  assign last_result_o   = last_q;

endmodule

// File: test/tb_top.sv
// tb_top: self-checking testbench for trb_producer_ring (TRB pushes, link TRBs, completions).
// Depends on rtl/trb_pkg.sv and rtl/trb_producer_ring.sv; a shadow ring in a class predicts
// every result strobe.
`timescale 1ns / 1ps

module tb_top;
  import trb_pkg::*;

  localparam int SLOTS         = SLOT_COUNT_DEF;
  localparam int STALL_LIMIT   = 1000;
  localparam int LATENCY_PAUSE = 8;
  localparam int PHASE_ITEMS   = 64;

  // One request as presented on the start port
  typedef struct {
    logic        func;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic        tag_present;
    logic [7:0]  tag;
    logic [63:0] pointer;
  } ring_req_t;

  // One strobed result
  typedef struct {
    logic [1:0]  kind;
    logic [63:0] addr;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic [7:0]  tag;
    logic        last;
  } ring_beat_t;

  // Shadow copy of the ring state; turns each accepted request into the writes and
  // completion answers it must produce
  class ring_shadow;
    logic [63:0] ring_base;
    int unsigned enq_slot;
    logic        cycle;
    logic [7:0]  tag_mem [SLOTS];
    logic        tag_valid [SLOTS];
    bit          slot_written [SLOTS];
    ring_beat_t  due_results [$];
    int          fail_count;

    function new();
      ring_base  = '0;
      enq_slot   = 0;
      cycle      = 1'b1;
      fail_count = 0;
      foreach (tag_valid[i]) begin
        tag_valid[i]    = 1'b0;
        tag_mem[i]      = '0;
        slot_written[i] = 1'b0;
      end
    endfunction

    function void set_base(logic [63:0] b);
      ring_base = b;
    endfunction

    function ring_beat_t beat(logic [1:0] kind, logic [63:0] addr, logic [31:0] w0,
                              logic [31:0] w1, logic [31:0] w2, logic [31:0] w3,
                              logic [7:0] tag, logic last);
      ring_beat_t b;
      b.kind  = kind;
      b.addr  = addr;
      b.word0 = w0;
      b.word1 = w1;
      b.word2 = w2;
      b.word3 = w3;
      b.tag   = tag;
      b.last  = last;
      return b;
    endfunction

    // Accepted request: update the shadow ring and queue what it must emit
    function void take_request(ring_req_t r);
      int unsigned slot;
      logic [63:0] idx;
      logic [31:0] w3;
      if (r.func == FUNC_PUSH) begin
        slot = (enq_slot >= SLOTS - 1) ? 0 : enq_slot;
        tag_valid[slot]    = r.tag_present;
        tag_mem[slot]      = r.tag_present ? r.tag : '0;
        slot_written[slot] = 1'b1;
        w3 = {r.word3[31:1], cycle};
        due_results.push_back(beat(KIND_WRITE, ring_base + 64'(slot) * 16, r.word0, r.word1,
                                   r.word2, w3, '0, (slot + 1) < (SLOTS - 1)));
        slot++;
        if (slot >= SLOTS - 1) begin
          // last slot reached: link TRB back to the base, wrap and flip the cycle bit
          due_results.push_back(beat(KIND_WRITE, ring_base + 64'(slot) * 16, ring_base[31:0],
                                     ring_base[63:32], '0, LINK_CTRL | {31'd0, cycle}, '0,
                                     1'b1));
          enq_slot = 0;
          cycle    = ~cycle;
        end else begin
          enq_slot = slot;
        end
      end else begin
        idx = (r.pointer - ring_base) >> 4;
        if (idx >= SLOTS) begin
          due_results.push_back(beat(KIND_RANGE, '0, '0, '0, '0, '0, '0, 1'b1));
        end else if (tag_valid[idx]) begin
          due_results.push_back(beat(KIND_TAG, '0, '0, '0, '0, '0, tag_mem[idx], 1'b1));
          tag_valid[idx] = 1'b0;
          tag_mem[idx]   = '0;
        end else begin
          due_results.push_back(beat(KIND_NO_WAITER, '0, '0, '0, '0, '0, '0, 1'b1));
        end
      end
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, got %0h", field, want, got);
        fail_count++;
      end
    endfunction

    // Strobed result: must match the oldest pending one field by field
    function void check_result(ring_beat_t got);
      ring_beat_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing pending: kind %0d addr %0h", got.kind, got.addr);
        fail_count++;
        return;
      end
      want = due_results.pop_front();
      compare("result_kind", want.kind, got.kind);
      compare("write_address", want.addr, got.addr);
      compare("out_word0", want.word0, got.word0);
      compare("out_word1", want.word1, got.word1);
      compare("out_word2", want.word2, got.word2);
      compare("out_word3", want.word3, got.word3);
      compare("delivered_tag", want.tag, got.tag);
      compare("last_result", want.last, got.last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [63:0] cfg_data_i;
  logic        start;
  logic        busy;
  logic        func_i;
  logic [31:0] trb_word0_i;
  logic [31:0] trb_word1_i;
  logic [31:0] trb_word2_i;
  logic [31:0] trb_word3_i;
  logic        tag_present_i;
  logic [7:0]  waiter_tag_i;
  logic [63:0] event_pointer_i;
  logic        result_strobe_o;
  logic [1:0]  result_kind_o;
  logic [63:0] write_address_o;
  logic [31:0] out_word0_o;
  logic [31:0] out_word1_o;
  logic [31:0] out_word2_o;
  logic [31:0] out_word3_o;
  logic [7:0]  delivered_tag_o;
  logic        last_result_o;

  ring_shadow sb;
  int         stall_cycles = 0;

  trb_producer_ring #(
    .SLOT_COUNT(SLOTS),
    .TAG_BITS  (TAG_BITS_DEF)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .trb_word0_i    (trb_word0_i),
    .trb_word1_i    (trb_word1_i),
    .trb_word2_i    (trb_word2_i),
    .trb_word3_i    (trb_word3_i),
    .tag_present_i  (tag_present_i),
    .waiter_tag_i   (waiter_tag_i),
    .event_pointer_i(event_pointer_i),
    .result_strobe_o(result_strobe_o),
    .result_kind_o  (result_kind_o),
    .write_address_o(write_address_o),
    .out_word0_o    (out_word0_o),
    .out_word1_o    (out_word1_o),
    .out_word2_o    (out_word2_o),
    .out_word3_o    (out_word3_o),
    .delivered_tag_o(delivered_tag_o),
    .last_result_o  (last_result_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      sb.check_result(ring_beat_t'{result_kind_o, write_address_o, out_word0_o, out_word1_o,
                                   out_word2_o, out_word3_o, delivered_tag_o, last_result_o});
    end
  end

  // Watchdog: any transfer restarts the count
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic ring_req_t push_req(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                                         logic [31:0] w3, logic tp, logic [7:0] tag);
    ring_req_t r;
    r.func        = FUNC_PUSH;
    r.word0       = w0;
    r.word1       = w1;
    r.word2       = w2;
    r.word3       = w3;
    r.tag_present = tp;
    r.tag         = tag;
    r.pointer     = {$urandom, $urandom};
    return r;
  endfunction

  function automatic ring_req_t event_req(logic [63:0] ptr);
    ring_req_t r;
    r         = push_req($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)));
    r.func    = FUNC_EVENT;
    r.pointer = ptr;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Pushes dominate; completions mostly hit pushed slots, preferring ones that hold a tag; the
  // rest land below or past the ring, or at a random pointer
  function automatic ring_req_t random_req();
    ring_req_t   r;
    int unsigned sel;
    int unsigned slot;
    int unsigned cand;
    bit          found;
    bit          found_valid;
    logic [63:0] ptr;
    r = push_req($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 3) != 0,
                 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < 70) return r;
    sel         = $urandom_range(0, 99);
    found       = 1'b0;
    found_valid = 1'b0;
    slot        = 0;
    if (sel < 75) begin
      for (int i = 0; i < 32 && !found_valid; i++) begin
        cand = $urandom_range(0, SLOTS - 2);
        if (sb.slot_written[cand]) begin
          slot        = cand;
          found       = 1'b1;
          found_valid = sb.tag_valid[cand];
        end
      end
      if (!found) return r;
      ptr = sb.ring_base + 64'(slot) * 16 + 64'($urandom_range(0, 15));
    end else if (sel < 85) begin
      ptr = sb.ring_base - 64'($urandom_range(1, 4096));
    end else if (sel < 93) begin
      ptr = sb.ring_base + 64'(SLOTS * 16) + 64'($urandom_range(0, 1 << 20));
    end else begin
      ptr = {$urandom, $urandom};
    end
    return event_req(ptr);
  endfunction

  // Present one request and hold it until the block takes it
  task automatic send_req(ring_req_t r, int gap);
    start           <= 1'b1;
    func_i          <= r.func;
    trb_word0_i     <= r.word0;
    trb_word1_i     <= r.word1;
    trb_word2_i     <= r.word2;
    trb_word3_i     <= r.word3;
    tag_present_i   <= r.tag_present;
    waiter_tag_i    <= r.tag;
    event_pointer_i <= r.pointer;
    do @(posedge clk_i); while (busy);
    sb.take_request(r);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop requesting and wait for every pending result
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_base(logic [63:0] b);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= b;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_base(b);
  endtask

  // Stimulus
  initial begin
    logic [63:0] phase_base [6];
    bit          no_gap;
    sb = new();
    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= '0;
    start           <= 1'b0;
    func_i          <= FUNC_PUSH;
    trb_word0_i     <= '0;
    trb_word1_i     <= '0;
    trb_word2_i     <= '0;
    trb_word3_i     <= '0;
    tag_present_i   <= 1'b0;
    waiter_tag_i    <= '0;
    event_pointer_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, tag store behavior, odd pointers
    write_base(64'd0);
    send_req(push_req('1, '1, '1, '1, 1'b1, 8'hFF), pick_gap());
    send_req(push_req('0, '0, '0, 32'd1, 1'b1, 8'h00), pick_gap());
    send_req(push_req(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0,
                      8'hA5), pick_gap());
    send_req(push_req(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 32'h0F0F_0F0E, 1'b1,
                      8'h5A), pick_gap());
    send_req(event_req(sb.ring_base), pick_gap());                        // tag FF
    send_req(event_req(sb.ring_base), pick_gap());                        // already taken
    send_req(event_req(sb.ring_base + 64'd16), pick_gap());               // tag zero
    send_req(event_req(sb.ring_base + 64'd47), pick_gap());               // push had no tag
    send_req(event_req(sb.ring_base + 64'd56), pick_gap());               // unaligned, 5A
    send_req(event_req(sb.ring_base - 64'd1), pick_gap());                // below base
    send_req(event_req(sb.ring_base + 64'(SLOTS * 16)), pick_gap());      // one past ring
    send_req(event_req(sb.ring_base + 64'((SLOTS - 1) * 16)), pick_gap()); // link slot
    send_req(event_req('1), pick_gap());
    send_req(push_req('0, '1, '0, '1, 1'b1, 8'h81), 0);
    send_req(event_req(sb.ring_base + 64'd64), 0);

    // Random phases, each under its own ring base
    phase_base[0] = 64'hFFFF_FFFF_FFFF_FFF0;
    phase_base[1] = {$urandom, $urandom} & ~64'hF;
    phase_base[2] = {$urandom, $urandom} | 64'h1;
    phase_base[3] = '1;
    phase_base[4] = {$urandom, $urandom};
    phase_base[5] = 64'd0;
    foreach (phase_base[ph]) begin
      wait_idle();
      write_base(phase_base[ph]);
      no_gap = ($urandom_range(0, 2) == 0);
      repeat (PHASE_ITEMS) send_req(random_req(), no_gap ? 0 : pick_gap());
    end

    wait_idle();
    repeat (LATENCY_PAUSE) @(posedge clk_i);
    if (sb.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
